>>> rtl/rpkb_pkg.sv
// Shared types and constants for the radio packet to KISS bridge.
// Used by rpkb_front, rpkb_queue, rpkb_back and the top level.
`default_nettype none

package rpkb_pkg;

    // Work item opcodes passed from the parser to the frame builder
    localparam logic [1:0] OP_HEADER = 2'd0;  // FEND, type byte and AX.25 header
    localparam logic [1:0] OP_BYTE   = 2'd1;  // one payload byte, escaped
    localparam logic [1:0] OP_REPORT = 2'd2;  // optional closing FEND, then report

    // Report codes
    localparam logic [1:0] RPT_GOOD        = 2'd0;
    localparam logic [1:0] RPT_PAYLOAD_BAD = 2'd1;
    localparam logic [1:0] RPT_HEADER_BAD  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEST    = 2'd0;
    localparam logic [1:0] CFG_SOURCE  = 2'd1;
    localparam logic [1:0] CFG_CONTROL = 2'd2;
    localparam logic [1:0] CFG_PID     = 2'd3;

    localparam logic [7:0]  FEND         = 8'hC0;
    localparam logic [7:0]  FESC         = 8'hDB;
    localparam logic [7:0]  TFEND        = 8'hDC;
    localparam logic [7:0]  TFESC        = 8'hDD;
    localparam logic [7:0]  DATA_FRAME   = 8'h00;
    localparam logic [7:0]  SYNC1        = 8'h48;
    localparam logic [7:0]  SYNC2        = 8'h65;
    localparam logic [15:0] CMD_TRANSMIT = 16'h1003;

    localparam logic [55:0] DEST_RESET    = 56'd44644984207091324;
    localparam logic [55:0] SOURCE_RESET  = 56'd44644984207091299;
    localparam logic [7:0]  CONTROL_RESET = 8'd3;
    localparam logic [7:0]  PID_RESET     = 8'd240;

    // Header burst: FEND, type byte, then 16 header bytes at index 2..17
    localparam logic [4:0] HDR_FIRST_IDX = 5'd2;
    localparam logic [4:0] HDR_LAST_IDX  = 5'd17;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic [1:0]  code;
        logic [15:0] command;
        logic [15:0] length;
        logic        fwd;
    } t_cmd;

    typedef struct packed {
        logic [55:0] dest;
        logic [55:0] source;
        logic [7:0]  control;
        logic [7:0]  pid;
    } t_ax25_cfg;

endpackage

`default_nettype wire

>>> rtl/rpkb_front.sv
// Packet parser: sync hunt, header fields, Fletcher-style sums and checks.
// Emits work items (rpkb_pkg::t_cmd) for the frame builder.
`default_nettype none

module rpkb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_rx_byte,
    output rpkb_pkg::t_cmd     o_cmd,
    output logic               o_push
);
    import rpkb_pkg::*;

    localparam logic [3:0] PH_HUNT    = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CMD_HI  = 4'd2;
    localparam logic [3:0] PH_CMD_LO  = 4'd3;
    localparam logic [3:0] PH_LEN_HI  = 4'd4;
    localparam logic [3:0] PH_LEN_LO  = 4'd5;
    localparam logic [3:0] PH_HCHK_A  = 4'd6;
    localparam logic [3:0] PH_HCHK_B  = 4'd7;
    localparam logic [3:0] PH_PAYLOAD = 4'd8;
    localparam logic [3:0] PH_FCHK_A  = 4'd9;
    localparam logic [3:0] PH_FCHK_B  = 4'd10;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [15:0] r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_exp, n_exp;
    logic        r_fwd, n_fwd;

    logic [7:0]  add_a, add_b;
    logic [7:0]  hdr_a, hdr_b;
    logic [15:0] count_inc;
    logic        fwd_next;

    assign add_a     = r_sum_a + i_rx_byte;
    assign add_b     = r_sum_b + add_a;
    assign hdr_a     = r_sum_a - r_exp;
    assign hdr_b     = r_sum_b - r_sum_a;
    assign count_inc = r_count + 16'd1;
    assign fwd_next  = (r_cmd == CMD_TRANSMIT);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_exp   = r_exp;
        n_fwd   = r_fwd;
        o_push  = 1'b0;
        o_cmd   = '{op: OP_BYTE, data: i_rx_byte, code: RPT_GOOD,
                    command: r_cmd, length: r_len, fwd: r_fwd};
        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == SYNC1) n_phase = PH_SYNC2;
                end
                PH_SYNC2: begin
                    if (i_rx_byte == SYNC2) begin
                        n_phase = PH_CMD_HI;
                        n_sum_a = '0;
                        n_sum_b = '0;
                        n_count = '0;
                        n_cmd   = '0;
                        n_len   = '0;
                        n_fwd   = 1'b0;
                    end else if (i_rx_byte != SYNC1) begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_CMD_HI: begin
                    n_cmd   = {i_rx_byte, 8'h00};
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = PH_CMD_LO;
                end
                PH_CMD_LO: begin
                    n_cmd   = {r_cmd[15:8], i_rx_byte};
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len   = {i_rx_byte, 8'h00};
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = {r_len[15:8], i_rx_byte};
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = PH_HCHK_A;
                end
                PH_HCHK_A: begin
                    n_exp   = i_rx_byte;
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = PH_HCHK_B;
                end
                PH_HCHK_B: begin
                    // back out the first check byte to get the header sums
                    if (hdr_a != r_exp || hdr_b != i_rx_byte) begin
                        o_push       = 1'b1;
                        o_cmd.op     = OP_REPORT;
                        o_cmd.code   = RPT_HEADER_BAD;
                        o_cmd.fwd    = 1'b0;
                        n_phase      = PH_HUNT;
                    end else begin
                        n_sum_a = add_a;
                        n_sum_b = add_b;
                        n_fwd   = fwd_next;
                        n_count = '0;
                        o_push  = fwd_next;
                        o_cmd.op = OP_HEADER;
                        n_phase = (r_len == 16'd0) ? PH_FCHK_A : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    o_push  = r_fwd;
                    n_count = count_inc;
                    if (count_inc >= r_len) n_phase = PH_FCHK_A;
                end
                PH_FCHK_A: begin
                    n_exp   = i_rx_byte;
                    n_phase = PH_FCHK_B;
                end
                PH_FCHK_B: begin
                    o_push     = 1'b1;
                    o_cmd.op   = OP_REPORT;
                    o_cmd.code = (r_sum_a == r_exp && r_sum_b == i_rx_byte) ?
                                 RPT_GOOD : RPT_PAYLOAD_BAD;
                    n_phase    = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
            r_cmd   <= '0;
            r_len   <= '0;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_exp   <= '0;
            r_fwd   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_exp   <= n_exp;
            r_fwd   <= n_fwd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rpkb_queue.sv
// Short work-item queue between the parser and the frame builder.
// Depends on rpkb_pkg for the item type.
`default_nettype none

module rpkb_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  rpkb_pkg::t_cmd     i_cmd,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic               o_full,
    output rpkb_pkg::t_cmd     o_cmd
);
    import rpkb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == FULL_CNT);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rpkb_back.sv
// Frame builder: expands work items into KISS beats and reports, one beat
// per cycle if unstalled, into the output register. Depends on rpkb_pkg.
`default_nettype none

module rpkb_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  rpkb_pkg::t_ax25_cfg  i_cfg,
    input  wire logic            i_valid,
    input  rpkb_pkg::t_cmd       i_cmd,
    output logic                 o_pop,
    input  wire logic            i_stall,
    output logic                 o_valid,
    output logic                 o_kind,
    output logic [7:0]           o_kiss_byte,
    output logic [1:0]           o_report_code,
    output logic [15:0]          o_command,
    output logic [15:0]          o_payload_length,
    output logic                 o_forwarded,
    output logic                 o_last
);
    import rpkb_pkg::*;

    logic [15:0][7:0] hdr_bytes;
    logic [3:0]       hdr_sel;
    logic [4:0]       r_idx, n_idx;
    logic             r_esc, n_esc;

    logic             load_ok, beat_go;
    logic [7:0]       raw_byte;
    logic             escapable, needs_esc, final_beat;
    logic             beat_kind;
    logic [7:0]       beat_byte;

    logic             r_out_valid;
    logic             r_kind, r_last, r_fwd;
    logic [7:0]       r_byte;
    logic [1:0]       r_code;
    logic [15:0]      r_cmd, r_len;

    assign hdr_bytes = i_cfg;
    assign hdr_sel   = 4'(r_idx - HDR_FIRST_IDX);
    assign load_ok   = !r_out_valid || !i_stall;
    assign beat_go   = i_valid && load_ok;

    always_comb begin
        raw_byte   = i_cmd.data;
        escapable  = 1'b0;
        beat_kind  = 1'b0;
        final_beat = 1'b0;
        n_idx      = r_idx;
        unique case (i_cmd.op)
            OP_HEADER: begin
                if (r_idx == 5'd0) begin
                    raw_byte = FEND;
                end else if (r_idx == 5'd1) begin
                    raw_byte = DATA_FRAME;
                end else begin
                    raw_byte  = hdr_bytes[4'd15 - hdr_sel];
                    escapable = 1'b1;
                end
                final_beat = (r_idx == HDR_LAST_IDX);
            end
            OP_BYTE: begin
                escapable  = 1'b1;
                final_beat = 1'b1;
            end
            OP_REPORT: begin
                // forwarded packets get a closing FEND ahead of the report
                if (i_cmd.fwd && r_idx == 5'd0) begin
                    raw_byte = FEND;
                end else begin
                    beat_kind  = 1'b1;
                    final_beat = 1'b1;
                end
            end
            default: begin
                beat_kind  = 1'b1;
                final_beat = 1'b1;
            end
        endcase

        needs_esc = escapable && (raw_byte == FEND || raw_byte == FESC);
        n_esc     = r_esc;
        beat_byte = raw_byte;
        if (needs_esc && !r_esc) begin
            beat_byte  = FESC;
            final_beat = 1'b0;
            n_esc      = 1'b1;
        end else if (r_esc) begin
            beat_byte = (raw_byte == FEND) ? TFEND : TFESC;
            n_esc     = 1'b0;
        end

        // advance to the next source byte once its escape pair is out
        if (!(needs_esc && !r_esc)) n_idx = final_beat ? 5'd0 : r_idx + 5'd1;
        o_pop = beat_go && final_beat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (beat_go) begin
                r_idx <= n_idx;
                r_esc <= n_esc;
            end
            if (load_ok) r_out_valid <= i_valid;
        end
    end

    // payload of the output register: no reset
    always_ff @(posedge i_clk) begin
        if (beat_go) begin
            r_kind <= beat_kind;
            r_last <= final_beat;
            r_byte <= beat_kind ? 8'h00 : beat_byte;
            r_code <= beat_kind ? i_cmd.code : RPT_GOOD;
            r_cmd  <= beat_kind ? i_cmd.command : 16'h0000;
            r_len  <= beat_kind ? i_cmd.length : 16'h0000;
            r_fwd  <= beat_kind && i_cmd.fwd;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_kiss_byte      = r_byte;
    assign o_report_code    = r_code;
    assign o_command        = r_cmd;
    assign o_payload_length = r_len;
    assign o_forwarded      = r_fwd;
    assign o_last           = r_last;

endmodule

`default_nettype wire

>>> rtl/radio_packet_to_kiss_bridge.sv
// Radio packet to KISS bridge, top level: config registers, parser, queue, builder.
// Unstalled throughput: one radio byte per cycle in, one output beat per cycle out.
// Each item is written into the queue, then its beats into the output register.
// A good transmit header yields an 18 to 34 beat burst; the builder drains a beat per
// cycle unless stalled; input stalls only while the QUEUE_DEPTH-entry queue is full.
// Reset (synchronous, active low) clears parser, queue and output; config to defaults.
`default_nettype none

module radio_packet_to_kiss_bridge #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [55:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic [7:0]       o_kiss_byte,
    output logic [1:0]       o_report_code,
    output logic [15:0]      o_command,
    output logic [15:0]      o_payload_length,
    output logic             o_forwarded,
    output logic             o_last
);
    import rpkb_pkg::*;

    t_ax25_cfg r_cfg;
    t_cmd      push_cmd, head_cmd;
    logic      push, pop, q_valid, q_full, rx_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{dest: DEST_RESET, source: SOURCE_RESET,
                       control: CONTROL_RESET, pid: PID_RESET};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEST:    r_cfg.dest    <= i_cfg_data;
                CFG_SOURCE:  r_cfg.source  <= i_cfg_data;
                CFG_CONTROL: r_cfg.control <= i_cfg_data[7:0];
                CFG_PID:     r_cfg.pid     <= i_cfg_data[7:0];
            endcase
        end
    end

    assign o_stall   = q_full;
    assign rx_accept = i_valid && !q_full;

    rpkb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (rx_accept),
        .i_rx_byte (i_rx_byte),
        .o_cmd     (push_cmd),
        .o_push    (push)
    );

    rpkb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (head_cmd)
    );

    rpkb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (q_valid),
        .i_cmd            (head_cmd),
        .o_pop            (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_kiss_byte      (o_kiss_byte),
        .o_report_code    (o_report_code),
        .o_command        (o_command),
        .o_payload_length (o_payload_length),
        .o_forwarded      (o_forwarded),
        .o_last           (o_last)
    );

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_report_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_last)
        else $error("report beat not marked last");

    a_dropped_not_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind && o_report_code == RPT_HEADER_BAD |-> !o_forwarded)
        else $error("dropped packet reported as forwarded");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> rx_accept)
        else $error("work item pushed without an accepted byte");

endmodule

`default_nettype wire

>>> dv/tb_radio_packet_to_kiss_bridge.sv
// Testbench for radio_packet_to_kiss_bridge: random and directed radio packets in,
// KISS beats and packet reports out, checked against an in-bench scoreboard.
// Depends on rpkb_pkg and the bridge RTL only.
`timescale 1ns / 1ps

module tb_radio_packet_to_kiss_bridge;
    import rpkb_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        kind;
        logic [7:0]  kiss_byte;
        logic [1:0]  code;
        logic [15:0] command;
        logic [15:0] length;
        logic        fwd;
        logic        last;
    } t_bridge_beat;

    typedef enum logic [3:0] {
        PARSE_HUNT, PARSE_SYNC2, PARSE_CMD_HI, PARSE_CMD_LO, PARSE_LEN_HI, PARSE_LEN_LO,
        PARSE_HCHK_A, PARSE_HCHK_B, PARSE_PAYLOAD, PARSE_FCHK_A, PARSE_FCHK_B
    } t_parse_phase;

    // Tracks the parser, builds the expected KISS beats and reports, checks the outputs
    class kiss_scoreboard;
        logic [55:0]  dest_word;
        logic [55:0]  source_word;
        logic [7:0]   ctrl_byte;
        logic [7:0]   pid_byte;
        t_parse_phase phase;
        logic [15:0]  pay_count;
        logic [15:0]  cmd_word;
        logic [15:0]  len_word;
        logic [7:0]   run_a;
        logic [7:0]   run_b;
        logic [7:0]   first_check;
        logic         sending;
        t_bridge_beat pending_beats[$];
        int           error_count;
        int           beats_seen;

        function new();
            dest_word   = DEST_RESET;
            source_word = SOURCE_RESET;
            ctrl_byte   = CONTROL_RESET;
            pid_byte    = PID_RESET;
            phase       = PARSE_HUNT;
            pay_count   = '0;
            cmd_word    = '0;
            len_word    = '0;
            run_a       = '0;
            run_b       = '0;
            first_check = '0;
            sending     = 1'b0;
            error_count = 0;
            beats_seen  = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [55:0] value);
            case (idx)
                CFG_DEST:    dest_word   = value;
                CFG_SOURCE:  source_word = value;
                CFG_CONTROL: ctrl_byte   = value[7:0];
                CFG_PID:     pid_byte    = value[7:0];
                default:     ;
            endcase
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            error_count++;
        endtask

        function void push_kiss(logic [7:0] value);
            t_bridge_beat beat;
            beat = '0;
            beat.kiss_byte = value;
            pending_beats.push_back(beat);
        endfunction

        function void push_escaped(logic [7:0] value);
            if (value == FEND) begin
                push_kiss(FESC);
                push_kiss(TFEND);
            end else if (value == FESC) begin
                push_kiss(FESC);
                push_kiss(TFESC);
            end else begin
                push_kiss(value);
            end
        endfunction

        function void push_report(logic [1:0] code);
            t_bridge_beat beat;
            beat = '0;
            beat.kind    = 1'b1;
            beat.code    = code;
            beat.command = cmd_word;
            beat.length  = len_word;
            beat.fwd     = sending;
            pending_beats.push_back(beat);
        endfunction

        function void add_sum(logic [7:0] value);
            run_a = run_a + value;
            run_b = run_b + run_a;
        endfunction

        // Advance the parser by one accepted radio byte
        function void take_radio_byte(logic [7:0] value);
            int         queued;
            int         k;
            logic [7:0] hdr_a;
            logic [7:0] hdr_b;
            queued = pending_beats.size();
            case (phase)
                PARSE_HUNT: if (value == SYNC1) phase = PARSE_SYNC2;
                PARSE_SYNC2: begin
                    if (value == SYNC2) begin
                        phase     = PARSE_CMD_HI;
                        run_a     = '0;
                        run_b     = '0;
                        pay_count = '0;
                        cmd_word  = '0;
                        len_word  = '0;
                        sending   = 1'b0;
                    end else if (value != SYNC1) begin
                        phase = PARSE_HUNT;
                    end
                end
                PARSE_CMD_HI: begin
                    cmd_word = {value, 8'h00};
                    add_sum(value);
                    phase = PARSE_CMD_LO;
                end
                PARSE_CMD_LO: begin
                    cmd_word[7:0] = value;
                    add_sum(value);
                    phase = PARSE_LEN_HI;
                end
                PARSE_LEN_HI: begin
                    len_word = {value, 8'h00};
                    add_sum(value);
                    phase = PARSE_LEN_LO;
                end
                PARSE_LEN_LO: begin
                    len_word[7:0] = value;
                    add_sum(value);
                    phase = PARSE_HCHK_A;
                end
                PARSE_HCHK_A: begin
                    first_check = value;
                    add_sum(value);
                    phase = PARSE_HCHK_B;
                end
                PARSE_HCHK_B: begin
                    // back out the first check byte to get the sums over the header
                    hdr_a = run_a - first_check;
                    hdr_b = run_b - run_a;
                    if (hdr_a != first_check || hdr_b != value) begin
                        push_report(RPT_HEADER_BAD);
                        phase = PARSE_HUNT;
                    end else begin
                        add_sum(value);
                        sending = (cmd_word == CMD_TRANSMIT);
                        if (sending) begin
                            push_kiss(FEND);
                            push_kiss(DATA_FRAME);
                            for (k = 6; k >= 0; k--) push_escaped(dest_word[8*k +: 8]);
                            for (k = 6; k >= 0; k--) push_escaped(source_word[8*k +: 8]);
                            push_escaped(ctrl_byte);
                            push_escaped(pid_byte);
                        end
                        pay_count = '0;
                        phase = (len_word == 16'd0) ? PARSE_FCHK_A : PARSE_PAYLOAD;
                    end
                end
                PARSE_PAYLOAD: begin
                    add_sum(value);
                    if (sending) push_escaped(value);
                    pay_count = pay_count + 16'd1;
                    if (pay_count >= len_word) phase = PARSE_FCHK_A;
                end
                PARSE_FCHK_A: begin
                    first_check = value;
                    phase = PARSE_FCHK_B;
                end
                PARSE_FCHK_B: begin
                    if (sending) push_kiss(FEND);
                    push_report((run_a == first_check && run_b == value) ?
                                RPT_GOOD : RPT_PAYLOAD_BAD);
                    phase = PARSE_HUNT;
                end
                default: phase = PARSE_HUNT;
            endcase
            if (pending_beats.size() > queued)
                pending_beats[pending_beats.size() - 1].last = 1'b1;
        endfunction

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("beat %0d %s: got %0h, want %0h", beats_seen, name, got, want));
        endtask

        task check_beat(t_bridge_beat got);
            t_bridge_beat want;
            beats_seen++;
            if (pending_beats.size() == 0) begin
                report($sformatf("beat %0d arrived with nothing pending", beats_seen));
                return;
            end
            want = pending_beats.pop_front();
            check_field("kind", got.kind, want.kind);
            check_field("kiss_byte", got.kiss_byte, want.kiss_byte);
            check_field("report_code", got.code, want.code);
            check_field("command", got.command, want.command);
            check_field("payload_length", got.length, want.length);
            check_field("forwarded", got.fwd, want.fwd);
            check_field("last", got.last, want.last);
        endtask

        task flush_check();
            if (pending_beats.size() != 0)
                report($sformatf("%0d beats never arrived", pending_beats.size()));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = '0;
    logic [55:0] i_cfg_data = '0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte  = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    logic        o_kind;
    logic [7:0]  o_kiss_byte;
    logic [1:0]  o_report_code;
    logic [15:0] o_command;
    logic [15:0] o_payload_length;
    logic        o_forwarded;
    logic        o_last;

    kiss_scoreboard radio_sb;
    t_bridge_beat   seen_beat;
    logic [7:0]     payload_q[$];
    int             packet_bytes = 0;
    int             tx_gap_max   = 15;
    int             rx_gap_max   = 15;
    int             rx_hold_req  = 0;
    int             hold_left    = 0;
    int             stall_left   = 0;
    int             cycle_count  = 0;

    radio_packet_to_kiss_bridge i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("radio_packet_to_kiss_bridge regression: fail");
            $finish;
        end
    end

    // Output side: take beats, then stall for a drawn count or a requested long hold
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            seen_beat = '{kind: o_kind, kiss_byte: o_kiss_byte, code: o_report_code,
                          command: o_command, length: o_payload_length,
                          fwd: o_forwarded, last: o_last};
            radio_sb.check_beat(seen_beat);
            stall_left = $urandom_range(0, rx_gap_max);
        end
        if (rx_hold_req > 0) begin
            hold_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= value;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        radio_sb.take_radio_byte(value);
    endtask

    // Frame one packet around payload_q; a bad header stops after its check bytes
    task automatic send_packet(input logic [15:0] cmd, input logic [15:0] len,
                               input bit hdr_err, input bit pay_err);
        logic [7:0] frame[$];
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        int         k;
        frame = '{SYNC1, SYNC2, cmd[15:8], cmd[7:0], len[15:8], len[7:0]};
        sum_a = '0;
        sum_b = '0;
        for (k = 2; k < 6; k++) begin
            sum_a = sum_a + frame[k];
            sum_b = sum_b + sum_a;
        end
        frame.push_back(sum_a);
        frame.push_back(sum_b);
        if (hdr_err) begin
            frame[6 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        end else begin
            for (k = 6; k < 8; k++) begin
                sum_a = sum_a + frame[k];
                sum_b = sum_b + sum_a;
            end
            foreach (payload_q[k]) begin
                sum_a = sum_a + payload_q[k];
                sum_b = sum_b + sum_a;
                frame.push_back(payload_q[k]);
            end
            frame.push_back(sum_a);
            frame.push_back(sum_b);
            if (pay_err) frame[frame.size() - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        end
        foreach (frame[k]) send_byte(frame[k]);
        packet_bytes += frame.size();
    endtask

    function automatic logic [7:0] random_payload_byte();
        case ($urandom_range(0, 7))
            0:       return FEND;
            1:       return FESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [55:0] random_addr();
        logic [55:0] addr;
        int          k;
        for (k = 0; k < 7; k++) addr[8*k +: 8] = random_payload_byte();
        return addr;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [55:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        radio_sb.set_register(idx, value);
    endtask

    // Junk in the upper data bits of the byte registers must be dropped
    task automatic load_header(input logic [55:0] dest, input logic [55:0] src,
                               input logic [7:0] ctl, input logic [7:0] pid);
        write_reg(CFG_DEST, dest);
        write_reg(CFG_SOURCE, src);
        write_reg(CFG_CONTROL, {16'($urandom), 32'($urandom), ctl});
        write_reg(CFG_PID, {16'($urandom), 32'($urandom), pid});
    endtask

    // Drop valid and hold until every pending beat is out, plus pipeline slack
    task automatic drain_outputs();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (radio_sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic random_traffic(input int target);
        int          start;
        int          pick;
        int          n;
        logic [15:0] cmd;
        logic [15:0] len;
        logic [7:0]  value;
        start = packet_bytes;
        while (packet_bytes - start < target) begin
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    do value = 8'($urandom_range(0, 255)); while (value == SYNC1);
                    send_byte(value);
                end
            end else if (pick < 14) begin
                send_byte(SYNC1);
                do value = 8'($urandom_range(0, 255));
                while (value == SYNC1 || value == SYNC2);
                send_byte(value);
            end else if (pick < 34) begin
                send_packet(16'($urandom), 16'($urandom), 1'b1, 1'b0);
            end else begin
                cmd = ($urandom_range(0, 4) < 3) ? CMD_TRANSMIT : 16'($urandom);
                len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(11, 40))
                                                   : 16'($urandom_range(0, 10));
                payload_q = {};
                repeat (len) payload_q.push_back(random_payload_byte());
                send_packet(cmd, len, 1'b0, $urandom_range(0, 6) == 0);
            end
        end
    endtask

    initial begin
        radio_sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // stray bytes, a broken sync pair, then a repeated H before a good sync
        send_byte(8'h00);
        send_byte(SYNC1);
        send_byte(8'h11);
        send_byte(SYNC1);
        payload_q = '{FEND, FESC, 8'hFF};
        send_packet(CMD_TRANSMIT, 16'd3, 1'b0, 1'b0);
        // other command, empty payload, bad footer
        payload_q = {};
        send_packet(16'h0000, 16'd0, 1'b0, 1'b1);
        send_packet(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        drain_outputs();

        load_header('0, '0, 8'h00, 8'h00);
        random_traffic(100);
        drain_outputs();

        load_header('1, '1, 8'hFF, 8'hFF);
        random_traffic(100);
        drain_outputs();

        // every header byte escaped: longest burst; then back the output up
        load_header({7{FEND}}, {7{FESC}}, FEND, FESC);
        rx_hold_req = 400;
        tx_gap_max  = 0;
        payload_q   = {};
        repeat (24) payload_q.push_back(random_payload_byte());
        send_packet(CMD_TRANSMIT, 16'd24, 1'b0, 1'b0);
        drain_outputs();
        random_traffic(80);
        drain_outputs();

        load_header(random_addr(), random_addr(), random_payload_byte(), random_payload_byte());
        random_traffic(100);
        drain_outputs();

        radio_sb.flush_check();
        if (radio_sb.error_count == 0)
            $display("radio_packet_to_kiss_bridge regression: pass");
        else
            $display("radio_packet_to_kiss_bridge regression: fail");
        $finish;
    end

endmodule
